// ----- design/pcbp_pkg.sv -----
// Package for the prefix-code bit packer: field widths, table geometry and
// command codes. Depends on nothing; the interfaces and the core import it.
package pcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

  localparam int CMD_W   = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;

  localparam int TABLE_W     = CODE_W + LEN_W;
  localparam int TABLE_DEPTH = 256;

  // Pending bits joined with one full code word.
  localparam int ACC_W = PEND_W + CODE_W;
  localparam int TOT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

endpackage

// ----- design/pcbp_if.sv -----
// Handshake channels of the prefix-code bit packer: the command input and the
// byte output. Depends on pcbp_pkg for the field widths.
interface pcbp_in_if import pcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, command, symbol, code_bits, code_length, input ready);
  modport sink (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface pcbp_out_if import pcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- design/pcbp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the code table of the bit packer.
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/prefix_code_bit_packer_core.sv -----
// Top level of the prefix-code bit packer: command sequencer, code table and
// the shared byte extractor. Depends on pcbp_pkg, pcbp_if and pcbp_ram.
//
// Usage. Commands arrive as words on in_chan (valid/ready). A load word writes
// one symbol's code word and length into the 256-entry code table; lengths
// above the code length limit are saturated and code bits above the length are
// dropped. An encode word appends the symbol's code, first bit most
// significant, to the pending bits and sends every full byte on out_chan. A
// flush word sends the zero-padded leftover byte, if any, then a trailer byte
// holding the pad count (1 to 8), and empties the pending bits. The last flag
// marks the final byte caused by one command word.
//
// Operation. The block takes one command word at a time and is ready only
// while idle. A load writes the table as the word is accepted. An encode reads
// the table, joins the code with the pending bits, then sends each output byte
// from the shared extract shifter (0 to 4 bytes) and finally stores the leftover
// bits. A flush sends the leftover byte, if any, then the trailer. Output bytes sit
// in a single output register; while the receiver stalls, the sequencer waits
// and nothing is lost. Reset empties the pending bits and the output register;
// the code table is not cleared and must be loaded before a symbol is encoded.
module prefix_code_bit_packer_core import pcbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pcbp_in_if.sink     in_chan,
  pcbp_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_FLUSH_DATA,
    ST_FLUSH_TRAIL
  } state_t;

  state_t              state;
  logic [PEND_W-1:0]   pending_bits;
  logic [PCNT_W-1:0]   pending_count;
  logic [ACC_W-1:0]    acc;
  logic [TOT_W-1:0]    total;
  logic                out_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;

  logic                accept;
  logic                slot_free;
  logic                load_we;
  logic                table_re;
  logic [LEN_W-1:0]    len_sat;
  logic [CODE_W:0]     code_mask;
  logic [TABLE_W-1:0]  table_wdata;
  logic [TABLE_W-1:0]  table_rdata;
  logic [CODE_W-1:0]   rd_code;
  logic [LEN_W-1:0]    rd_len;
  logic [ACC_W-1:0]    acc_next;
  logic [TOT_W-1:0]    total_next;
  logic [TOT_W-1:0]    total_less;
  logic [ACC_W-1:0]    extract;
  logic [BYTE_W-1:0]   keep_mask;
  logic [PCNT_W:0]     pad;
  logic [BYTE_W:0]     flush_shift;

  assign accept    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid || out_chan.ready;

  assign in_chan.ready     = (state == ST_IDLE);
  assign out_chan.valid    = out_valid;
  assign out_chan.out_byte = out_byte;
  assign out_chan.last     = out_last;

  // Load path: saturate the length and clear code bits above it.
  always_comb begin
    len_sat     = (in_chan.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                             : in_chan.code_length;
    code_mask   = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
    table_wdata = {len_sat, in_chan.code_bits & code_mask[CODE_W-1:0]};
  end

  assign load_we  = accept && (in_chan.command == CMD_LOAD);
  assign table_re = accept && (in_chan.command == CMD_ENCODE);

  pcbp_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_chan.symbol),
    .wdata (table_wdata),
    .re    (table_re),
    .raddr (in_chan.symbol),
    .rdata (table_rdata)
  );

  assign rd_code = table_rdata[CODE_W-1:0];
  assign rd_len  = table_rdata[TABLE_W-1:CODE_W];

  // Join the pending bits above the new code word.
  always_comb begin
    acc_next   = (ACC_W'(pending_bits) << rd_len) | ACC_W'(rd_code);
    total_next = TOT_W'(pending_count) + rd_len;
  end

  // The shared extractor: the top byte of the valid bits, and the leftover mask.
  always_comb begin
    total_less = total - TOT_W'(BYTE_W);
    extract    = acc >> total_less;
    keep_mask  = (BYTE_W'(1) << total[PCNT_W-1:0]) - BYTE_W'(1);
    pad        = (PCNT_W+1)'(BYTE_W) - (PCNT_W+1)'(pending_count);
    flush_shift = (BYTE_W+1)'(pending_bits) << pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending_bits  <= '0;
      pending_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_chan.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_chan.command == CMD_ENCODE) begin
              state <= ST_READ;
            end else if (in_chan.command == CMD_FLUSH) begin
              state <= (pending_count != '0) ? ST_FLUSH_DATA : ST_FLUSH_TRAIL;
            end
          end
        end
        ST_READ: begin
          acc   <= acc_next;
          total <= total_next;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (total >= TOT_W'(BYTE_W)) begin
            if (slot_free) begin
              out_valid <= 1'b1;
              out_byte  <= extract[BYTE_W-1:0];
              out_last  <= (total_less < TOT_W'(BYTE_W));
              total     <= total_less;
            end
          end else begin
            // Fewer than eight bits remain: they become the pending bits.
            pending_bits  <= acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
            pending_count <= total[PCNT_W-1:0];
            state         <= ST_IDLE;
          end
        end
        ST_FLUSH_DATA: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_byte  <= flush_shift[BYTE_W-1:0];
            out_last  <= 1'b0;
            state     <= ST_FLUSH_TRAIL;
          end
        end
        ST_FLUSH_TRAIL: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            out_byte      <= BYTE_W'(pad);
            out_last      <= 1'b1;
            pending_bits  <= '0;
            pending_count <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/pcbp_tb_pkg.sv -----
// Scoreboard for the prefix-code bit packer testbench: predicts the packed byte
// stream from accepted command words and checks every output byte against it.
// Depends on pcbp_pkg for field widths, table geometry and command codes.
package pcbp_tb_pkg;
  import pcbp_pkg::*;

  // The fourth command code is reserved and must be ignored by the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] out_val;
    logic              last;
  } packed_byte_t;

  class pcbp_byte_board;
    logic [CODE_W-1:0] code_of [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_of  [TABLE_DEPTH];
    bit                loaded  [TABLE_DEPTH];
    logic [PEND_W-1:0] held_bits;
    int                held_count;
    packed_byte_t      expected_bytes[$];
    int                errors;
    int                bytes_seen;
    int                loads, encodes, flushes, ignored;

    function new();
      foreach (loaded[i]) begin
        loaded[i]  = 1'b0;
        code_of[i] = '0;
        len_of[i]  = '0;
      end
      held_bits  = '0;
      held_count = 0;
      errors     = 0;
      bytes_seen = 0;
      loads      = 0;
      encodes    = 0;
      flushes    = 0;
      ignored    = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [BYTE_W-1:0] val, logic is_last);
      packed_byte_t e;
      e.out_val = val;
      e.last    = is_last;
      expected_bytes.push_back(e);
    endfunction

    // Update the model for one accepted command word and queue its bytes.
    function void note_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                            logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
      logic [63:0] acc;
      logic [63:0] mask;
      int          n;
      int          total;
      int          pad;
      if (cmd == CMD_LOAD) begin
        n = len;
        if (n > LEN_LIMIT) n = LEN_LIMIT;
        mask = (64'd1 << n) - 64'd1;
        len_of[sym]  = n[LEN_W-1:0];
        code_of[sym] = code & mask[CODE_W-1:0];
        loaded[sym]  = 1'b1;
        loads++;
      end else if (cmd == CMD_ENCODE) begin
        encodes++;
        n = len_of[sym];
        if (n != 0) begin
          mask  = (64'd1 << n) - 64'd1;
          acc   = ({{(64-PEND_W){1'b0}}, held_bits} << n) | ({32'd0, code_of[sym]} & mask);
          total = held_count + n;
          while (total >= 8) begin
            push_byte(acc[total-1 -: 8], (total - 8) < 8);
            total -= 8;
          end
          mask       = (64'd1 << total) - 64'd1;
          held_bits  = acc[PEND_W-1:0] & mask[PEND_W-1:0];
          held_count = total;
        end
      end else if (cmd == CMD_FLUSH) begin
        flushes++;
        pad = 8 - held_count;
        if (held_count != 0) push_byte(BYTE_W'({held_bits, 1'b0} << (pad - 1)), 1'b0);
        push_byte(BYTE_W'(pad), 1'b1);
        held_bits  = '0;
        held_count = 0;
      end else begin
        ignored++;
      end
    endfunction

    // Compare one accepted output byte with the oldest expectation.
    function void check_byte(logic [BYTE_W-1:0] val, logic is_last);
      packed_byte_t e;
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output byte %02h last %0b", val, is_last);
        return;
      end
      e = expected_bytes.pop_front();
      if (e.out_val !== val || e.last !== is_last) begin
        errors++;
        if (errors <= 10)
          $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                   bytes_seen, e.out_val, e.last, val, is_last);
      end
    endfunction
  endclass

endpackage

// ----- tb/prefix_code_bit_packer_core_tb.sv -----
// Testbench top for the prefix-code bit packer: drives load, encode and flush
// words, stalls the byte receiver at random and checks every byte.
// Depends on pcbp_pkg, pcbp_if, pcbp_tb_pkg and the design under test.
module prefix_code_bit_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcbp_pkg::*;
  import pcbp_tb_pkg::*;

  // A slow correct run is about 310 words, each with an idle burst, the work of
  // the command and up to 4 bytes that may each be stalled. The limit leaves a
  // wide margin on top of that.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed for the block to settle after the last expected byte.
  localparam int SETTLE       = 20;
  localparam int RANDOM_WORDS = 280;
  localparam int STEADY_FROM  = 240;

  logic clk = 1'b0;
  logic rst;

  pcbp_in_if  in_chan ();
  pcbp_out_if out_chan ();

  prefix_code_bit_packer_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #5 clk = ~clk;

  pcbp_byte_board sb = new();

  // When set, neither side idles; used in the closing stretch of the run.
  bit steady = 1'b0;
  int cycles = 0;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("prefix_code_bit_packer_core: mismatch");
      $finish;
    end
  end

  // Byte receiver. Each accepted byte is checked in the same step it is seen,
  // using values sampled before the edge's updates land. Ready then idles in
  // random bursts, or stays high in the steady stretch.
  initial begin : byte_receiver
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_chan.valid && out_chan.ready)
        sb.check_byte(out_chan.out_byte, out_chan.last);
      if (rst) begin
        out_chan.ready <= 1'b0;
      end else if (steady) begin
        out_chan.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one command word and hold it until the block takes it. Outside the
  // steady stretch the sender may idle first for a burst of cycles. Valid is
  // never lowered and raised in the same step, so back-to-back words stay
  // clean.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.command     <= cmd;
    in_chan.symbol      <= sym;
    in_chan.code_bits   <= code;
    in_chan.code_length <= len;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_word(cmd, sym, code, len);
  endtask

  task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                           input logic [LEN_W-1:0] len);
    send_word(CMD_LOAD, sym, code, len);
  endtask

  // Encode and flush carry random junk in the fields they do not use.
  task automatic encode_sym(input logic [SYM_W-1:0] sym);
    send_word(CMD_ENCODE, sym, $urandom, LEN_W'($urandom));
  endtask

  task automatic flush_bits();
    send_word(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
  endtask

  // Stop offering words until every expected byte has arrived, then wait out the
  // settle time so that the block can finish any command that produces no bytes.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    int               pick;

    rst                 <= 1'b1;
    in_chan.valid       <= 1'b0;
    in_chan.command     <= CMD_LOAD;
    in_chan.symbol      <= '0;
    in_chan.code_bits   <= '0;
    in_chan.code_length <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A zero-length code produces no bytes at all.
    load_code(8'd0, 32'hFFFF_FFFF, 6'd0);
    encode_sym(8'd0);
    // Longest code from an empty buffer: four full bytes.
    load_code(8'd255, 32'hFFFF_FFFF, 6'd32);
    encode_sym(8'd255);
    // Single bit, leaving one bit pending.
    load_code(8'd1, 32'h0000_0001, 6'd1);
    encode_sym(8'd1);
    // Overlong lengths saturate to the limit.
    load_code(8'd2, 32'hA5A5_A5A5, 6'd63);
    encode_sym(8'd2);
    load_code(8'd6, 32'h1234_5678, 6'd33);
    encode_sym(8'd6);
    // Code bits above the stored length are dropped.
    load_code(8'd3, 32'hFFFF_FFFF, 6'd3);
    encode_sym(8'd3);
    flush_bits();
    // A flush with nothing pending sends only the trailer of eight.
    flush_bits();
    // The reserved command code must be ignored.
    send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Seven pending bits give the smallest pad of one.
    load_code(8'd4, 32'h0000_007F, 6'd7);
    encode_sym(8'd4);
    flush_bits();
    // Exactly one byte, nothing left over.
    load_code(8'd5, 32'h0000_0080, 6'd8);
    encode_sym(8'd5);
    flush_bits();
    load_code(8'd170, 32'h0000_2AAA, 6'd14);
    encode_sym(8'd170);
    encode_sym(8'd255);

    // Hold off the sender once until the byte stream is fully drained.
    drain();

    // Random part: mostly encodes of loaded symbols, with enough loads to keep
    // the table changing, flushes at random points and a few reserved words.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain();
      if (i == STEADY_FROM) begin
        drain();
        steady = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 16) begin
        sym = SYM_W'($urandom);
        if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(33, 63));
        else len = LEN_W'($urandom_range(0, 32));
        load_code(sym, $urandom, len);
      end else if (pick < 82) begin
        // Only loaded entries are ever encoded.
        do sym = SYM_W'($urandom); while (!sb.loaded[sym]);
        encode_sym(sym);
      end else if (pick < 95) begin
        flush_bits();
      end else begin
        send_word(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
      end
    end

    drain();

    $display("Run covered %0d loads, %0d encodes, %0d flushes and %0d reserved words;",
             sb.loads, sb.encodes, sb.flushes, sb.ignored);
    $display("%0d output bytes were checked, %0d of them wrong or unexpected.",
             sb.bytes_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("prefix_code_bit_packer_core: match");
    end else begin
      $display("prefix_code_bit_packer_core: mismatch");
    end
    $finish;
  end

endmodule
